FILE: hdl/tclfu_pkg.sv
package tclfu_pkg;

  localparam int TAG_W       = 63;
  localparam int OFF_W       = 63;
  localparam int TOP_W       = 48;
  localparam int ENT_W       = 13;
  localparam int WAY_OUT_W   = 4;
  localparam int CNT_W       = 32;
  localparam int ES_W        = 5;
  localparam int TB_W        = 4;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;

  localparam int CACHE_WAYS_DEFAULT = 16;

  localparam logic [CNT_W-1:0] COUNT_TOP = 32'hffff_ffff;

  localparam logic [ES_W-1:0] ES_MIN   = 5'd9;
  localparam logic [ES_W-1:0] ES_MAX   = 5'd16;
  localparam logic [ES_W-1:0] ES_RESET = 5'd12;
  localparam logic [TB_W-1:0] TB_MIN   = 4'd6;
  localparam logic [TB_W-1:0] TB_MAX   = 4'd13;
  localparam logic [TB_W-1:0] TB_RESET = 4'd9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENTRY_SHIFT = 1'b0,
    REG_TABLE_BITS  = 1'b1
  } cfg_reg_t;

  // lookup request into the way array
  typedef struct packed {
    logic             update;
    logic [TAG_W-1:0] tag;
  } tclfu_req_t;

  // lookup answer from the way array
  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
  } tclfu_res_t;

endpackage

FILE: hdl/tclfu_in_if.sv
interface tclfu_in_if import tclfu_pkg::*;;
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] table_tag;
  logic [OFF_W-1:0] guest_offset;

  modport source (output valid, output table_tag, output guest_offset, input ready);
  modport sink   (input valid, input table_tag, input guest_offset, output ready);
endinterface

FILE: hdl/tclfu_out_if.sv
interface tclfu_out_if import tclfu_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way_index;
  logic [TOP_W-1:0]     top_index;
  logic [ENT_W-1:0]     entry_index;

  modport source (output valid, output hit, output way_index, output top_index,
                  output entry_index, input ready);
  modport sink   (input valid, input hit, input way_index, input top_index,
                  input entry_index, output ready);
endinterface

FILE: hdl/tclfu_ways.sv
module tclfu_ways import tclfu_pkg::*; #(
  parameter int CACHE_WAYS = CACHE_WAYS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  tclfu_req_t req,
  output tclfu_res_t res
);

  localparam int WAY_W = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
  localparam int NP    = 1 << WAY_W;

  logic [TAG_W-1:0] tags   [CACHE_WAYS];
  logic [CNT_W-1:0] counts [CACHE_WAYS];

  logic                  tag_nz;
  logic [CACHE_WAYS-1:0] match;
  logic [CACHE_WAYS-1:0] first_hit;
  logic [CACHE_WAYS-1:0] at_edge;
  logic [CACHE_WAYS-1:0] victim;
  logic                  hit;
  logic                  halve;
  logic [WAY_W-1:0]      hit_idx;
  logic [WAY_W-1:0]      victim_idx;
  logic [WAY_W-1:0]      way_sel;
  logic [WAY_W+WAY_OUT_W-1:0] way_wide;

  logic [CNT_W-1:0] node_val [2*NP-1];
  logic [WAY_W-1:0] node_idx [2*NP-1];

  assign tag_nz = (req.tag != '0);

  always_comb begin
    for (int w = 0; w < CACHE_WAYS; w++) begin
      match[w]   = tag_nz && (tags[w] == req.tag);
      at_edge[w] = (counts[w] == COUNT_TOP - CNT_W'(1));
    end
  end

  assign first_hit = match & (~match + CACHE_WAYS'(1));
  assign hit       = |match;
  assign halve     = |(first_hit & at_edge);

  always_comb begin
    hit_idx = '0;
    for (int w = 0; w < CACHE_WAYS; w++) begin
      if (first_hit[w]) hit_idx = hit_idx | WAY_W'(w);
    end
  end

  // minimum tree, ties go to the left (lower) way; pad leaves never win
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      if (i < CACHE_WAYS) node_val[NP-1+i] = counts[i];
      else node_val[NP-1+i] = COUNT_TOP;
      node_idx[NP-1+i] = WAY_W'(i);
    end
    for (int n = NP - 2; n >= 0; n--) begin
      if (node_val[2*n+2] < node_val[2*n+1]) begin
        node_val[n] = node_val[2*n+2];
        node_idx[n] = node_idx[2*n+2];
      end else begin
        node_val[n] = node_val[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end
    end
  end

  assign victim_idx = node_idx[0];

  always_comb begin
    for (int w = 0; w < CACHE_WAYS; w++) begin
      victim[w] = tag_nz && !hit && (victim_idx == WAY_W'(w));
    end
  end

  assign way_sel  = hit ? hit_idx : (tag_nz ? victim_idx : '0);
  assign way_wide = {{WAY_OUT_W{1'b0}}, way_sel};
  assign res.hit  = hit;
  assign res.way  = way_wide[WAY_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < CACHE_WAYS; w++) begin
        tags[w]   <= '0;
        counts[w] <= '0;
      end
    end else if (req.update) begin
      for (int w = 0; w < CACHE_WAYS; w++) begin
        logic [CNT_W-1:0] cnt_after;
        if (first_hit[w]) cnt_after = counts[w] + CNT_W'(1);
        else if (victim[w]) cnt_after = CNT_W'(1);
        else cnt_after = counts[w];
        counts[w] <= halve ? (cnt_after >> 1) : cnt_after;
        if (victim[w]) tags[w] <= req.tag;
      end
    end
  end

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    req.update |-> $onehot0(match))
    else $error("more than one way holds the lookup tag");

  a_victim_fill: assert property (@(posedge clk) disable iff (rst)
    (req.update && tag_nz && !hit) |=> (tags[$past(victim_idx)] == $past(req.tag)))
    else $error("replaced way did not take the new tag");

  a_halve_hit_way: assert property (@(posedge clk) disable iff (rst)
    (req.update && halve) |=> (counts[$past(hit_idx)] == (COUNT_TOP >> 1)))
    else $error("saturating way not halved to mid count");

endmodule

FILE: hdl/table_cache_lfu_lookup_core.sv
// Pipeline: a transferred lookup is held in the s1 register; its result is loaded into the
//   result register when s1 advances, which waits while a held result is not yet taken.
// Throughput: one lookup per cycle while results are taken; way state updates at the edge the result is
//   registered, so the next lookup sees it.
// Reset: synchronous; clears every tag and use count, empties both registers,
//   and sets entry_shift to 12 and table_bits to 9.
module table_cache_lfu_lookup_core import tclfu_pkg::*; #(
  parameter int CACHE_WAYS = CACHE_WAYS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  tclfu_in_if.sink               lookup,
  tclfu_out_if.source            result
);

  logic [ES_W-1:0] entry_shift;
  logic [TB_W-1:0] table_bits;
  logic [ES_W-1:0] es_wr;
  logic [TB_W-1:0] tb_wr;

  logic             s1_valid;
  logic [TAG_W-1:0] s1_tag;
  logic [OFF_W-1:0] s1_offset;
  logic             s1_advance;

  logic                 res_valid;
  logic                 res_hit;
  logic [WAY_OUT_W-1:0] res_way;
  logic [TOP_W-1:0]     res_top;
  logic [ENT_W-1:0]     res_ent;

  logic [ES_W-1:0]  split_shift;
  logic [OFF_W-1:0] top_full;
  logic [OFF_W-1:0] ent_full;
  logic [ENT_W-1:0] ent_mask;

  tclfu_req_t way_req;
  tclfu_res_t way_res;

  // clamp at write time; stored values are always in range
  always_comb begin
    if (cfg_data[ES_W-1:0] < ES_MIN) es_wr = ES_MIN;
    else if (cfg_data[ES_W-1:0] > ES_MAX) es_wr = ES_MAX;
    else es_wr = cfg_data[ES_W-1:0];
    if (cfg_data[TB_W-1:0] < TB_MIN) tb_wr = TB_MIN;
    else if (cfg_data[TB_W-1:0] > TB_MAX) tb_wr = TB_MAX;
    else tb_wr = cfg_data[TB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_shift <= ES_RESET;
      table_bits  <= TB_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENTRY_SHIFT: entry_shift <= es_wr;
        REG_TABLE_BITS:  table_bits  <= tb_wr;
        default: ;
      endcase
    end
  end

  assign s1_advance   = s1_valid && (!res_valid || result.ready);
  assign lookup.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (lookup.ready) s1_valid <= lookup.valid;
      res_valid <= s1_advance || (res_valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (lookup.valid && lookup.ready) begin
      s1_tag    <= lookup.table_tag;
      s1_offset <= lookup.guest_offset;
    end
  end

  // address split
  assign split_shift = entry_shift + ES_W'(table_bits);
  assign top_full    = s1_offset >> split_shift;
  assign ent_full    = s1_offset >> entry_shift;
  assign ent_mask    = ~({ENT_W{1'b1}} << table_bits);

  assign way_req.update = s1_advance;
  assign way_req.tag    = s1_tag;

  tclfu_ways #(
    .CACHE_WAYS(CACHE_WAYS)
  ) u_ways (
    .clk (clk),
    .rst (rst),
    .req (way_req),
    .res (way_res)
  );

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_hit <= way_res.hit;
      res_way <= way_res.way;
      res_top <= top_full[TOP_W-1:0];
      res_ent <= ent_full[ENT_W-1:0] & ent_mask;
    end
  end

  assign result.valid       = res_valid;
  assign result.hit         = res_hit;
  assign result.way_index   = res_way;
  assign result.top_index   = res_top;
  assign result.entry_index = res_ent;

  a_zero_tag: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_tag == '0) |=> (!res_hit && res_way == '0))
    else $error("zero tag produced a hit or a nonzero way");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready && s1_valid) |-> !lookup.ready)
    else $error("input taken while both stages are blocked");

  a_cfg_range: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (entry_shift >= ES_MIN && entry_shift <= ES_MAX
                   && table_bits >= TB_MIN && table_bits <= TB_MAX))
    else $error("configuration left out of its clamped range");

endmodule
